/* rtl/core/msc_pkg.sv */
// ----------------------------------------------------------------------------
// Magic signature classifier package
// Signature table, type class codes and shared types for the classifier.
// ----------------------------------------------------------------------------
package msc_pkg;

  localparam int MAX_LEN_DEF = 512;
  localparam int NUM_SIGS    = 30;
  localparam int SIG_BYTES_W = 8;

  // Text rule: printable * TEXT_NUM > length * TEXT_DEN.
  localparam int TEXT_NUM = 10;
  localparam int TEXT_DEN = 9;

  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_NUL   = 8'h00;

  localparam logic [4:0] CLS_OCTET = 5'd0;
  localparam logic [4:0] CLS_TEXT  = 5'd1;
  localparam logic [4:0] CLS_WEBP  = 5'd2;
  localparam logic [4:0] CLS_WAV   = 5'd3;
  localparam logic [4:0] CLS_PNG   = 5'd4;
  localparam logic [4:0] CLS_JPEG  = 5'd5;
  localparam logic [4:0] CLS_GIF   = 5'd6;
  localparam logic [4:0] CLS_BMP   = 5'd7;
  localparam logic [4:0] CLS_ICON  = 5'd8;
  localparam logic [4:0] CLS_TIFF  = 5'd9;
  localparam logic [4:0] CLS_SVG   = 5'd10;
  localparam logic [4:0] CLS_PDF   = 5'd11;
  localparam logic [4:0] CLS_ZIP   = 5'd12;
  localparam logic [4:0] CLS_GZIP  = 5'd13;
  localparam logic [4:0] CLS_ZSTD  = 5'd14;
  localparam logic [4:0] CLS_TAR   = 5'd15;
  localparam logic [4:0] CLS_7Z    = 5'd16;
  localparam logic [4:0] CLS_RAR   = 5'd17;
  localparam logic [4:0] CLS_MP4   = 5'd18;
  localparam logic [4:0] CLS_OGG   = 5'd19;
  localparam logic [4:0] CLS_FLAC  = 5'd20;
  localparam logic [4:0] CLS_MPEG  = 5'd21;
  localparam logic [4:0] CLS_ELF   = 5'd22;
  localparam logic [4:0] CLS_MACHO = 5'd23;
  localparam logic [4:0] CLS_JAVA  = 5'd24;
  localparam logic [4:0] CLS_WASM  = 5'd25;

  // Indexes of the RIFF container parts and the first ordinary table entry.
  localparam int SIG_RIFF     = 0;
  localparam int SIG_WEBP     = 1;
  localparam int SIG_WAVE     = 2;
  localparam int SIG_TABLE_LO = 3;

  localparam logic [8:0] SIG_OFF [NUM_SIGS] = '{
    9'd0, 9'd8, 9'd8, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0,
    9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd257, 9'd0,
    9'd0, 9'd4, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0
  };

  localparam logic [3:0] SIG_LEN [NUM_SIGS] = '{
    4'd4, 4'd4, 4'd4, 4'd8, 4'd3, 4'd6, 4'd6, 4'd2, 4'd4, 4'd4,
    4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd2, 4'd4, 4'd5, 4'd6,
    4'd6, 4'd4, 4'd4, 4'd4, 4'd3, 4'd2, 4'd4, 4'd4, 4'd4, 4'd4
  };

  // Offset plus length: the buffer must reach this many bytes.
  localparam logic [8:0] SIG_END [NUM_SIGS] = '{
    9'd4, 9'd12, 9'd12, 9'd8, 9'd3, 9'd6, 9'd6, 9'd2, 9'd4, 9'd4,
    9'd4, 9'd4, 9'd4, 9'd4, 9'd4, 9'd4, 9'd2, 9'd4, 9'd262, 9'd6,
    9'd6, 9'd8, 9'd4, 9'd4, 9'd3, 9'd2, 9'd4, 9'd4, 9'd4, 9'd4
  };

  localparam logic [4:0] SIG_CLS [NUM_SIGS] = '{
    CLS_OCTET, CLS_WEBP, CLS_WAV, CLS_PNG, CLS_JPEG, CLS_GIF, CLS_GIF,
    CLS_BMP, CLS_ICON, CLS_TIFF, CLS_TIFF, CLS_SVG, CLS_SVG, CLS_PDF,
    CLS_ZIP, CLS_ZIP, CLS_GZIP, CLS_ZSTD, CLS_TAR, CLS_7Z, CLS_RAR,
    CLS_MP4, CLS_OGG, CLS_FLAC, CLS_MPEG, CLS_MPEG, CLS_ELF, CLS_MACHO,
    CLS_JAVA, CLS_WASM
  };

  localparam logic [7:0] SIG_BYTES [NUM_SIGS][SIG_BYTES_W] = '{
    '{8'h52, 8'h49, 8'h46, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h57, 8'h45, 8'h42, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h57, 8'h41, 8'h56, 8'h45, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A},
    '{8'hFF, 8'hD8, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h47, 8'h49, 8'h46, 8'h38, 8'h37, 8'h61, 8'h00, 8'h00},
    '{8'h47, 8'h49, 8'h46, 8'h38, 8'h39, 8'h61, 8'h00, 8'h00},
    '{8'h42, 8'h4D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h49, 8'h49, 8'h2A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h4D, 8'h4D, 8'h00, 8'h2A, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h3C, 8'h73, 8'h76, 8'h67, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h3C, 8'h53, 8'h56, 8'h47, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h25, 8'h50, 8'h44, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h50, 8'h4B, 8'h03, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h50, 8'h4B, 8'h05, 8'h06, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h1F, 8'h8B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h28, 8'hB5, 8'h2F, 8'hFD, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h75, 8'h73, 8'h74, 8'h61, 8'h72, 8'h00, 8'h00, 8'h00},
    '{8'h37, 8'h7A, 8'hBC, 8'hAF, 8'h27, 8'h1C, 8'h00, 8'h00},
    '{8'h52, 8'h61, 8'h72, 8'h21, 8'h1A, 8'h07, 8'h00, 8'h00},
    '{8'h66, 8'h74, 8'h79, 8'h70, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h4F, 8'h67, 8'h67, 8'h53, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h66, 8'h4C, 8'h61, 8'h43, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h49, 8'h44, 8'h33, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hFF, 8'hFB, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h7F, 8'h45, 8'h4C, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hCF, 8'hFA, 8'hED, 8'hFE, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hCA, 8'hFE, 8'hBA, 8'hBE, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h61, 8'h73, 8'h6D, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  // Per-buffer flags handed from the tracker to the classifier.
  typedef struct packed {
    logic [NUM_SIGS-1:0] alive;
    logic                nul;
    logic                overflow;
  } sig_flags_t;

endpackage

/* rtl/core/magic_signature_classifier_top.sv */
// ----------------------------------------------------------------------------
// Magic signature classifier, top level
// Takes one buffer byte per cycle, tracks signature matches and the text
// statistics, and gives a type class when the buffer closes.
// The closing transaction passes the input, snapshot and output registers.
// Throughput: one byte transaction per cycle unless a closing transaction
// waits for the snapshot slot; the per-byte compare is combinational.
// Reset: synchronous rst clears the buffer state and all valid flags.
// ----------------------------------------------------------------------------
module magic_signature_classifier_top #(
  parameter int MAX_LEN = msc_pkg::MAX_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       has_byte,
  input  logic       is_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] type_class,
  output logic       overflowed
);
  import msc_pkg::*;

  localparam int POS_W = $clog2(MAX_LEN + 1);

  logic             in_full;
  logic [7:0]       byte_q;
  logic             has_q;
  logic             last_q;
  logic             go;
  logic             snap_free;
  logic             snap_take;
  logic             snap_valid;
  logic [POS_W-1:0] snap_pos;
  logic [POS_W-1:0] snap_prn;
  sig_flags_t       snap_flags;

  // A closing transaction waits only if the snapshot slot is still occupied.
  assign go       = in_full && (!last_q || snap_free);
  assign in_ready = !in_full || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_q <= data_byte;
      has_q  <= has_byte;
      last_q <= is_last;
    end
  end

  msc_track #(
    .MAX_LEN(MAX_LEN)
  ) u_track (
    .clk        (clk),
    .rst        (rst),
    .go         (go),
    .data_byte  (byte_q),
    .has_byte   (has_q),
    .is_last    (last_q),
    .snap_take  (snap_take),
    .snap_valid (snap_valid),
    .snap_free  (snap_free),
    .snap_pos   (snap_pos),
    .snap_prn   (snap_prn),
    .snap_flags (snap_flags)
  );

  msc_classify #(
    .MAX_LEN(MAX_LEN)
  ) u_classify (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (snap_valid),
    .snap_pos   (snap_pos),
    .snap_prn   (snap_prn),
    .snap_flags (snap_flags),
    .snap_take  (snap_take),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .type_class (type_class),
    .overflowed (overflowed)
  );

endmodule

/* rtl/core/msc_track.sv */
// ----------------------------------------------------------------------------
// Magic signature tracker
// Keeps the running buffer state, matches each byte against all signatures
// and captures a snapshot of the finished buffer for the classifier.
// ----------------------------------------------------------------------------
module msc_track #(
  parameter int MAX_LEN = msc_pkg::MAX_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                go,
  input  logic [7:0]                          data_byte,
  input  logic                                has_byte,
  input  logic                                is_last,
  input  logic                                snap_take,
  output logic                                snap_valid,
  output logic                                snap_free,
  output logic [$clog2(MAX_LEN+1)-1:0]        snap_pos,
  output logic [$clog2(MAX_LEN+1)-1:0]        snap_prn,
  output msc_pkg::sig_flags_t                 snap_flags
);
  import msc_pkg::*;

  localparam int POS_W = $clog2(MAX_LEN + 1);

  logic [POS_W-1:0]    pos, pos_next;
  logic [POS_W-1:0]    prn, prn_next;
  logic                nul, nul_next;
  logic                ovf, ovf_next;
  logic [NUM_SIGS-1:0] alive, alive_next;

  assign snap_free = !snap_valid || snap_take;

  always_comb begin
    logic [POS_W-1:0] off;
    logic [POS_W-1:0] rel;
    off        = '0;
    rel        = '0;
    pos_next   = pos;
    prn_next   = prn;
    nul_next   = nul;
    ovf_next   = ovf;
    alive_next = alive;
    if (has_byte) begin
      if (pos == POS_W'(MAX_LEN)) begin
        // Bytes past the kept window only mark the overflow.
        ovf_next = 1'b1;
      end else begin
        for (int k = 0; k < NUM_SIGS; k++) begin
          off = POS_W'(SIG_OFF[k]);
          rel = pos - off;
          if ((pos >= off) && (rel < POS_W'(SIG_LEN[k])) &&
              (SIG_BYTES[k][rel[2:0]] != data_byte)) begin
            alive_next[k] = 1'b0;
          end
        end
        if (data_byte == CHR_NUL) begin
          nul_next = 1'b1;
        end
        if ((data_byte >= CHR_SPACE) || (data_byte == CHR_TAB) ||
            (data_byte == CHR_LF) || (data_byte == CHR_CR)) begin
          prn_next = prn + 1'b1;
        end
        pos_next = pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      prn   <= '0;
      nul   <= 1'b0;
      ovf   <= 1'b0;
      alive <= '1;
    end else if (go) begin
      if (is_last) begin
        pos   <= '0;
        prn   <= '0;
        nul   <= 1'b0;
        ovf   <= 1'b0;
        alive <= '1;
      end else begin
        pos   <= pos_next;
        prn   <= prn_next;
        nul   <= nul_next;
        ovf   <= ovf_next;
        alive <= alive_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (go && is_last) begin
      snap_valid <= 1'b1;
    end else if (snap_take) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && is_last) begin
      snap_pos            <= pos_next;
      snap_prn            <= prn_next;
      snap_flags.alive    <= alive_next;
      snap_flags.nul      <= nul_next;
      snap_flags.overflow <= ovf_next;
    end
  end

endmodule

/* rtl/core/msc_classify.sv */
// ----------------------------------------------------------------------------
// Magic signature classifier stage
// Picks the winning signature or the text rule for a finished buffer and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module msc_classify #(
  parameter int MAX_LEN = msc_pkg::MAX_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                snap_valid,
  input  logic [$clog2(MAX_LEN+1)-1:0]        snap_pos,
  input  logic [$clog2(MAX_LEN+1)-1:0]        snap_prn,
  input  msc_pkg::sig_flags_t                 snap_flags,
  output logic                                snap_take,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [4:0]                          type_class,
  output logic                                overflowed
);
  import msc_pkg::*;

  localparam int POS_W  = $clog2(MAX_LEN + 1);
  localparam int PROD_W = POS_W + 4;

  logic [NUM_SIGS-1:0] sig_ok;
  logic                is_text;
  logic [4:0]          cls;

  assign snap_take = snap_valid && (!out_valid || out_ready);

  always_comb begin
    for (int k = 0; k < NUM_SIGS; k++) begin
      sig_ok[k] = snap_flags.alive[k] && (snap_pos >= POS_W'(SIG_END[k]));
    end
  end

  assign is_text = !snap_flags.nul &&
                   ((PROD_W'(snap_prn) * PROD_W'(TEXT_NUM)) >
                    (PROD_W'(snap_pos) * PROD_W'(TEXT_DEN)));

  always_comb begin
    cls = is_text ? CLS_TEXT : CLS_OCTET;
    // Walk downward so the earliest table entry wins.
    for (int k = NUM_SIGS - 1; k >= SIG_TABLE_LO; k--) begin
      if (sig_ok[k]) begin
        cls = SIG_CLS[k];
      end
    end
    if (sig_ok[SIG_RIFF] && sig_ok[SIG_WAVE]) begin
      cls = CLS_WAV;
    end
    if (sig_ok[SIG_RIFF] && sig_ok[SIG_WEBP]) begin
      cls = CLS_WEBP;
    end
    if (snap_pos == '0) begin
      cls = CLS_OCTET;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (snap_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take) begin
      type_class <= cls;
      overflowed <= snap_flags.overflow;
    end
  end

endmodule
